// ----- hw/rtl/kts_pkg.sv -----
// ----------------------------------------------------------------------------
// kts_pkg
// Shared types and constants for the keyed top-k score table.
// ----------------------------------------------------------------------------
package kts_pkg;

   localparam int KEY_W         = 64;
   localparam int SCORE_W       = 31;
   localparam int RANK_W        = 3;
   localparam int STATUS_W      = 3;
   localparam int MAX_ROWS      = 8;
   localparam int QUEUE_DEPTH   = 2;
   localparam int DEF_ENTRIES   = 8;
   localparam int DEF_KEY_CHARS = 8;

   typedef enum logic [STATUS_W-1:0] {
      ST_APPENDED  = 3'd0,
      ST_UPDATED   = 3'd1,
      ST_REPLACED  = 3'd2,
      ST_DROPPED   = 3'd3,
      ST_EMPTY_KEY = 3'd4
   } status_type;

   typedef struct packed {
      logic [KEY_W-1:0]   entry_key;
      logic [SCORE_W-1:0] entry_score;
   } req_type;

   typedef struct packed {
      logic [RANK_W-1:0]  rank;
      logic [KEY_W-1:0]   row_key;
      logic [SCORE_W-1:0] row_score;
      logic               row_valid;
      status_type         submit_status;
      logic               last_row;
   } rsp_type;

   // A classified request as it waits between the front and the back end.
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [SCORE_W-1:0] score;
      logic               empty_key;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SEARCH,
      BK_SORT,
      BK_EMIT
   } back_state_type;

endpackage

// ----- hw/rtl/kts_front.sv -----
// ----------------------------------------------------------------------------
// kts_front
// Request intake: trims the key to its character count, flags empty keys
// and pushes the classified request into the queue.
// ----------------------------------------------------------------------------
module kts_front #(
   parameter int KEY_CHARS = kts_pkg::DEF_KEY_CHARS
) (
   input  logic                  req_valid,
   input  kts_pkg::req_type      req_data,
   input  kts_pkg::q_status_type q_status,
   output logic                  req_stall,
   output logic                  push,
   output kts_pkg::item_type     push_item
);
   import kts_pkg::*;

   localparam logic [KEY_W-1:0] KEY_MASK = (KEY_CHARS >= 8) ? {KEY_W{1'b1}} :
      ((KEY_W'(1) << (8 * KEY_CHARS)) - KEY_W'(1));

   logic [KEY_W-1:0] trimmed_key;

   assign trimmed_key         = req_data.entry_key & KEY_MASK;
   assign req_stall           = q_status.full;
   assign push                = req_valid && !q_status.full;
   assign push_item.key       = trimmed_key;
   assign push_item.score     = req_data.entry_score;
   assign push_item.empty_key = (trimmed_key == '0);

endmodule

// ----- hw/rtl/kts_queue.sv -----
// ----------------------------------------------------------------------------
// kts_queue
// Short request queue that decouples intake from the table engine.
// ----------------------------------------------------------------------------
module kts_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic                  pop,
   input  kts_pkg::item_type     push_item,
   output kts_pkg::item_type     head_item,
   output kts_pkg::q_status_type q_status
);
   import kts_pkg::*;

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   item_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item      = slot_ff[rd_ptr_ff];
   assign q_status.empty = (fill_ff == '0);
   assign q_status.full  = (fill_ff == FILL_W'(QUEUE_DEPTH));

endmodule

// ----- hw/rtl/kts_back.sv -----
// ----------------------------------------------------------------------------
// kts_back
// Table engine: key search and insert, re-sort by neighbor swaps, and the
// emission of the ranked rows through the response register.
// ----------------------------------------------------------------------------
module kts_back #(
   parameter int ENTRIES = kts_pkg::DEF_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  kts_pkg::q_status_type q_status,
   input  kts_pkg::item_type     head_item,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output kts_pkg::rsp_type      rsp_data
);
   import kts_pkg::*;

   localparam int IDX_W    = $clog2(ENTRIES);
   localparam int CNT_W    = $clog2(ENTRIES + 1);
   localparam int EMIT_MAX = (ENTRIES < MAX_ROWS) ? ENTRIES : MAX_ROWS;

   back_state_type     state_ff, state_in;
   logic [KEY_W-1:0]   key_ff [ENTRIES];
   logic [KEY_W-1:0]   key_in [ENTRIES];
   logic [SCORE_W-1:0] score_ff [ENTRIES];
   logic [SCORE_W-1:0] score_in [ENTRIES];
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [IDX_W-1:0]   emit_idx_ff, emit_idx_in;
   status_type         status_ff, status_in;
   item_type           item_ff, item_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [ENTRIES-1:0] hit;
   logic [ENTRIES-1:0] gt_prev;
   logic [ENTRIES-1:0] lt_next;
   logic               hit_any;
   logic [IDX_W-1:0]   hit_idx;
   logic               table_full;
   logic               last_below;
   logic               move_up;
   logic               move_down;
   logic [IDX_W-1:0]   swap_lo;
   logic [CNT_W-1:0]   emit_rows;
   logic               emit_last;
   logic               out_free;
   logic               do_search;
   logic               do_swap;
   logic               do_emit;

   // Per-row compares, each at its own fixed place in the table.
   for (genvar g = 0; g < ENTRIES; g++) begin : g_row
      assign hit[g] = (CNT_W'(g) < count_ff) && (key_ff[g] == item_ff.key);
      if (g == 0) begin : g_first
         assign gt_prev[g] = 1'b0;
      end else begin : g_rest
         assign gt_prev[g] = score_ff[g] > score_ff[g-1];
      end
      if (g == ENTRIES - 1) begin : g_last
         assign lt_next[g] = 1'b0;
      end else begin : g_inner
         assign lt_next[g] = (CNT_W'(g + 1) < count_ff) && (score_ff[g] < score_ff[g+1]);
      end
   end

   always_comb begin
      hit_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (hit[i]) begin
            hit_idx = IDX_W'(i);
         end
      end
   end

   assign hit_any    = |hit;
   assign table_full = (count_ff == CNT_W'(ENTRIES));
   assign last_below = (score_ff[ENTRIES-1] <= item_ff.score);

   // The table is sorted before each request, so only the touched row can be
   // out of place, and it travels in one direction only.
   assign move_up   = gt_prev[pos_ff];
   assign move_down = lt_next[pos_ff];
   assign swap_lo   = move_up ? pos_ff - IDX_W'(1) : pos_ff;

   assign emit_rows = (count_ff < CNT_W'(EMIT_MAX)) ? count_ff : CNT_W'(EMIT_MAX);
   assign emit_last = (count_ff == '0) || (CNT_W'(emit_idx_ff) + CNT_W'(1) == emit_rows);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               state_in = BK_SEARCH;
            end
         end
         BK_SEARCH: begin
            if (item_ff.empty_key || (!hit_any && table_full && !last_below)) begin
               state_in = BK_EMIT;
            end else begin
               state_in = BK_SORT;
            end
         end
         BK_SORT: begin
            if (!move_up && !move_down) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (out_free && emit_last) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      do_search = 1'b0;
      do_swap   = 1'b0;
      do_emit   = 1'b0;
      unique case (state_ff)
         BK_IDLE:   pop       = !q_status.empty;
         BK_SEARCH: do_search = 1'b1;
         BK_SORT:   do_swap   = move_up || move_down;
         BK_EMIT:   do_emit   = out_free;
         default:   pop       = 1'b0;
      endcase
   end

   always_comb begin
      key_in       = key_ff;
      score_in     = score_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      emit_idx_in  = emit_idx_ff;
      status_in    = status_ff;
      item_in      = pop ? head_item : item_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      rsp_data_in  = rsp_data_ff;

      if (do_search) begin
         emit_idx_in = '0;
         priority if (item_ff.empty_key) begin
            status_in = ST_EMPTY_KEY;
         end else if (hit_any) begin
            score_in[hit_idx] = item_ff.score;
            pos_in            = hit_idx;
            status_in         = ST_UPDATED;
         end else if (!table_full) begin
            key_in[count_ff[IDX_W-1:0]]   = item_ff.key;
            score_in[count_ff[IDX_W-1:0]] = item_ff.score;
            pos_in                        = count_ff[IDX_W-1:0];
            count_in                      = count_ff + CNT_W'(1);
            status_in                     = ST_APPENDED;
         end else if (last_below) begin
            key_in[ENTRIES-1]   = item_ff.key;
            score_in[ENTRIES-1] = item_ff.score;
            pos_in              = IDX_W'(ENTRIES - 1);
            status_in           = ST_REPLACED;
         end else begin
            status_in = ST_DROPPED;
         end
      end

      if (do_swap) begin
         for (int i = 0; i < ENTRIES - 1; i++) begin
            if (IDX_W'(i) == swap_lo) begin
               key_in[i]     = key_ff[i+1];
               key_in[i+1]   = key_ff[i];
               score_in[i]   = score_ff[i+1];
               score_in[i+1] = score_ff[i];
            end
         end
         pos_in = move_up ? pos_ff - IDX_W'(1) : pos_ff + IDX_W'(1);
      end

      if (do_emit) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.submit_status = status_ff;
         rsp_data_in.last_row      = emit_last;
         if (count_ff == '0) begin
            rsp_data_in.rank      = '0;
            rsp_data_in.row_key   = '0;
            rsp_data_in.row_score = '0;
            rsp_data_in.row_valid = 1'b0;
         end else begin
            rsp_data_in.rank      = RANK_W'(emit_idx_ff);
            rsp_data_in.row_key   = key_ff[emit_idx_ff];
            rsp_data_in.row_score = score_ff[emit_idx_ff];
            rsp_data_in.row_valid = 1'b1;
         end
         emit_idx_in = emit_idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Rows at or above the fill count are never read, so they need no reset.
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      score_ff    <= score_in;
      pos_ff      <= pos_in;
      emit_idx_ff <= emit_idx_in;
      status_ff   <= status_in;
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hw/rtl/keyed_top_k_score_table.sv -----
// ----------------------------------------------------------------------------
// keyed_top_k_score_table
// Keyed table of the best scores, kept sorted by descending score.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_data  (key, score)
//   rsp      out        rsp_valid/rsp_stall   rsp_data  (one ranked row)
//
// A request is popped and then its key is searched; a table change adds one
// neighbor swap per step (0 to ENTRIES-1) and a closing check, and the rows
// (1 to min(ENTRIES, 8)) are loaded in turn into the response register.
// The front queue holds two requests, so intake runs ahead of the engine.
// Synchronous reset empties the table and the queue; rsp_stall holds the
// response register and pauses the row walk.
// ----------------------------------------------------------------------------
module keyed_top_k_score_table #(
   parameter int ENTRIES   = kts_pkg::DEF_ENTRIES,
   parameter int KEY_CHARS = kts_pkg::DEF_KEY_CHARS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  kts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output kts_pkg::rsp_type rsp_data
);
   import kts_pkg::*;

   q_status_type q_status;
   item_type     push_item;
   item_type     head_item;
   logic         push;
   logic         pop;

   kts_front #(
      .KEY_CHARS (KEY_CHARS)
   ) u_front (
      .req_valid (req_valid),
      .req_data  (req_data),
      .q_status  (q_status),
      .req_stall (req_stall),
      .push      (push),
      .push_item (push_item)
   );

   kts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .push_item (push_item),
      .head_item (head_item),
      .q_status  (q_status)
   );

   kts_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_item (head_item),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// Testbench for keyed_top_k_score_table
// Drives key/score requests with random gaps and checks every emitted table
// row against a local model of the sorted top-k table. It covers directed
// corner cases first, then random traffic over a small key pool.
// ----------------------------------------------------------------------------
module testbench;
   import kts_pkg::*;

   localparam int ENTRIES       = DEF_ENTRIES;
   localparam int KEY_CHARS     = DEF_KEY_CHARS;
   localparam int RANDOM_ITEMS  = 460;
   localparam int POOL_SIZE     = 12;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 80;
   localparam int SHOWN_ERRORS  = 10;
   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

   typedef struct {
      req_type data;
      bit      drain_first;
   } pending_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   pending_type pending_requests[$];
   rsp_type     expected_rows[$];

   // Local copy of the table.
   logic [KEY_W-1:0]   board_keys[ENTRIES];
   logic [SCORE_W-1:0] board_scores[ENTRIES];
   int                 board_count = 0;

   int  total_requests = 0;
   int  requests_sent  = 0;
   int  rows_checked   = 0;
   int  failures       = 0;
   int  status_seen[5] = '{default: 0};
   int  gap_left       = 0;
   int  stall_left     = 0;
   int  hold_left      = 0;
   int  idle_cycles    = 0;
   logic [KEY_W-1:0] key_pool[POOL_SIZE];

   keyed_top_k_score_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // Applies one request to the local table and queues the rows it produces.
   function automatic void apply_submission(input req_type r);
      logic [KEY_W-1:0]   key;
      logic [SCORE_W-1:0] score;
      logic [KEY_W-1:0]   swap_key;
      logic [SCORE_W-1:0] swap_score;
      status_type         status;
      rsp_type            row;
      int                 hit;
      int                 rows;
      if (KEY_CHARS >= 8)
         key = r.entry_key;
      else
         key = r.entry_key & ((64'd1 << (8 * KEY_CHARS)) - 64'd1);
      score = r.entry_score;
      hit = -1;
      if (key == '0) begin
         status = ST_EMPTY_KEY;
      end else begin
         for (int i = 0; i < board_count; i++)
            if (hit < 0 && board_keys[i] == key) hit = i;
         if (hit >= 0) begin
            board_scores[hit] = score;
            status = ST_UPDATED;
         end else if (board_count < ENTRIES) begin
            board_keys[board_count] = key;
            board_scores[board_count] = score;
            board_count++;
            status = ST_APPENDED;
         end else if (board_scores[ENTRIES-1] <= score) begin
            board_keys[ENTRIES-1] = key;
            board_scores[ENTRIES-1] = score;
            status = ST_REPLACED;
         end else begin
            status = ST_DROPPED;
         end
         // Bubble pass with a strict compare keeps equal scores in order.
         for (int i = 0; i + 1 < board_count; i++)
            for (int j = 0; j + 1 < board_count - i; j++)
               if (board_scores[j] < board_scores[j+1]) begin
                  swap_score = board_scores[j];
                  swap_key = board_keys[j];
                  board_scores[j] = board_scores[j+1];
                  board_keys[j] = board_keys[j+1];
                  board_scores[j+1] = swap_score;
                  board_keys[j+1] = swap_key;
               end
      end
      status_seen[int'(status)]++;
      if (board_count == 0) begin
         row = '0;
         row.submit_status = status;
         row.last_row = 1'b1;
         expected_rows.push_back(row);
      end else begin
         rows = (board_count < MAX_ROWS) ? board_count : MAX_ROWS;
         for (int i = 0; i < rows; i++) begin
            row.rank = RANK_W'(i);
            row.row_key = board_keys[i];
            row.row_score = board_scores[i];
            row.row_valid = 1'b1;
            row.submit_status = status;
            row.last_row = (i + 1 == rows);
            expected_rows.push_back(row);
         end
      end
   endfunction

   function automatic logic [KEY_W-1:0] random_key();
      logic [KEY_W-1:0] k;
      case ($urandom_range(0, 3))
         0: k = {$urandom, $urandom};
         1: k = KEY_W'($urandom_range(1, 255));
         2: k = KEY_W'($urandom_range(1, 255)) << (8 * $urandom_range(0, 7));
         default: k = {$urandom, $urandom} | 64'h1;
      endcase
      return k;
   endfunction

   function automatic logic [SCORE_W-1:0] random_score();
      logic [SCORE_W-1:0] s;
      case ($urandom_range(0, 5))
         0, 1, 2: s = SCORE_W'($urandom_range(0, 15));
         3:       s = ($urandom_range(0, 1) == 0) ? '0 : SCORE_MAX;
         default: s = SCORE_W'($urandom);
      endcase
      return s;
   endfunction

   task automatic add_request(input logic [KEY_W-1:0] key, input logic [SCORE_W-1:0] score,
                              input bit drain_first);
      pending_type p;
      p.data.entry_key = key;
      p.data.entry_score = score;
      p.drain_first = drain_first;
      pending_requests.push_back(p);
   endtask

   // Request driver.
   always @(posedge clock) begin
      pending_type head;
      bit          calm;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_submission(req_data);
            requests_sent++;
         end
         calm = ((requests_sent / 60) % 3) == 2;
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0 &&
                         !(pending_requests[0].drain_first && expected_rows.size() > 0)) begin
               head = pending_requests.pop_front();
               req_data <= head.data;
               req_valid <= 1'b1;
               gap_left = calm ? 0 : $urandom_range(0, 3);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Row monitor and checker; also owns the stall pattern.
   always @(posedge clock) begin
      rsp_type want;
      logic    next_stall;
      bit      calm;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         calm = ((rows_checked / 300) % 4) == 3;
         if (rsp_valid && !rsp_stall) begin
            if (expected_rows.size() == 0) begin
               failures++;
               if (failures <= SHOWN_ERRORS)
                  $display("Unexpected row: rank %0d key %h score %0d valid %0b status %0d",
                           rsp_data.rank, rsp_data.row_key, rsp_data.row_score,
                           rsp_data.row_valid, rsp_data.submit_status);
            end else begin
               want = expected_rows.pop_front();
               if (rsp_data.rank !== want.rank || rsp_data.row_key !== want.row_key ||
                   rsp_data.row_score !== want.row_score ||
                   rsp_data.row_valid !== want.row_valid ||
                   rsp_data.submit_status !== want.submit_status ||
                   rsp_data.last_row !== want.last_row) begin
                  failures++;
                  if (failures <= SHOWN_ERRORS) begin
                     $display("Row mismatch at row %0d:", rows_checked);
                     $display("  expected rank %0d key %h score %0d valid %0b status %0d last %0b",
                              want.rank, want.row_key, want.row_score, want.row_valid,
                              want.submit_status, want.last_row);
                     $display("  actual   rank %0d key %h score %0d valid %0b status %0d last %0b",
                              rsp_data.rank, rsp_data.row_key, rsp_data.row_score,
                              rsp_data.row_valid, rsp_data.submit_status, rsp_data.last_row);
                  end
               end
            end
            rows_checked++;
            // Two long stalls let the request queue fill up behind the engine.
            if (rows_checked == 200 || rows_checked == 1800) hold_left = HOLD_CYCLES;
            stall_left = calm ? 0 : $urandom_range(0, 3);
         end
         next_stall = 1'b0;
         if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            next_stall = 1'b1;
         end
         rsp_stall <= next_stall;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [KEY_W-1:0] key;
      int               pick;
      int               slot;
      for (int i = 0; i < ENTRIES; i++) begin
         board_keys[i] = '0;
         board_scores[i] = '0;
      end
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = random_key();

      // Directed part: empty table, fill with ties, updates, replace and drop.
      add_request('0, 31'd5, 1'b0);
      add_request('1, SCORE_MAX, 1'b0);
      add_request(64'h41, '0, 1'b0);
      add_request('0, 31'd123, 1'b0);
      add_request(64'h42, 31'd100, 1'b0);
      add_request(64'h43, 31'd100, 1'b0);
      add_request(64'h44, 31'd50, 1'b0);
      add_request(64'h45, 31'd100, 1'b0);
      add_request(64'h46, 31'd7, 1'b0);
      add_request(64'h47, 31'd100, 1'b0);
      add_request(64'h41, 31'd200, 1'b0);
      add_request('1, '0, 1'b0);
      add_request(64'h48, '0, 1'b1);
      add_request(64'h49, '0, 1'b0);
      add_request(64'h4A, 31'd3, 1'b0);
      add_request(64'h4B, 31'd1, 1'b0);
      add_request(64'h4B, 31'd3, 1'b0);
      add_request(64'h8000_0000_0000_0000, SCORE_MAX, 1'b0);
      add_request(64'h42, SCORE_MAX, 1'b0);
      add_request(64'h0000_0000_0000_0001, 31'h2AAA_AAAA, 1'b0);
      add_request(64'h5555_AAAA_5555_AAAA, 31'h5555_5555, 1'b0);
      add_request('0, SCORE_MAX, 1'b0);

      // Random part over a key pool a bit larger than the table.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         slot = $urandom_range(0, POOL_SIZE - 1);
         if (pick < 5) begin
            key = '0;
         end else if (pick < 18) begin
            key_pool[slot] = random_key();
            key = key_pool[slot];
         end else begin
            key = key_pool[slot];
         end
         add_request(key, random_score(), $urandom_range(0, 49) == 0);
      end
      total_requests = pending_requests.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      wait (requests_sent == total_requests && expected_rows.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d requests: %0d appended, %0d updated, %0d replaced, %0d dropped, %0d empty",
               requests_sent, status_seen[ST_APPENDED], status_seen[ST_UPDATED],
               status_seen[ST_REPLACED], status_seen[ST_DROPPED], status_seen[ST_EMPTY_KEY]);
      $display("Checked %0d table rows with %0d failures", rows_checked, failures);
      if (failures == 0 && expected_rows.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
